/* rtl/ddo_pkg.sv */
// ----------------------------------------------------------------------------
// ddo_pkg
// Shared constants, types and tables for the differential drive odometry
// block: register indexes, reset values, CORDIC settings and arctangents.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int STEP_W       = (CORDIC_STEPS > 1) ? $clog2(CORDIC_STEPS) : 1;

    // 0.60725293500888 in Q2.30, held at the CORDIC datapath width
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [1:0] REG_DIST   = 2'd0;
    localparam logic [1:0] REG_PERIOD = 2'd1;
    localparam logic [1:0] REG_RATE   = 2'd2;
    localparam logic [1:0] REG_TURNS  = 2'd3;

    localparam logic [31:0] DIST_RESET   = 32'd25108448;
    localparam logic [15:0] PERIOD_RESET = 16'd50;
    localparam logic [31:0] RATE_RESET   = 32'd1310720;
    localparam logic [31:0] TURNS_RESET  = 32'd1667232380;

    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [32:0] cos_q30;
        logic signed [32:0] sin_q30;
    } t_cordic_res;

    // atan(2^-i) as a binary angle, 2^32 per turn
    function automatic logic [31:0] atan_q32(input logic [4:0] idx);
        logic [31:0] v;
        unique case (idx)
            5'd0:  v = 32'h2000_0000;
            5'd1:  v = 32'h12E4_051E;
            5'd2:  v = 32'h09FB_385B;
            5'd3:  v = 32'h0511_11D4;
            5'd4:  v = 32'h028B_0D43;
            5'd5:  v = 32'h0145_D7E1;
            5'd6:  v = 32'h00A2_F61E;
            5'd7:  v = 32'h0051_7C55;
            5'd8:  v = 32'h0028_BE53;
            5'd9:  v = 32'h0014_5F2F;
            5'd10: v = 32'h000A_2F98;
            5'd11: v = 32'h0005_17CC;
            5'd12: v = 32'h0002_8BE6;
            5'd13: v = 32'h0001_45F3;
            5'd14: v = 32'h0000_A2FA;
            5'd15: v = 32'h0000_517D;
            5'd16: v = 32'h0000_28BE;
            5'd17: v = 32'h0000_145F;
            5'd18: v = 32'h0000_0A30;
            5'd19: v = 32'h0000_0518;
            5'd20: v = 32'h0000_028C;
            5'd21: v = 32'h0000_0146;
            5'd22: v = 32'h0000_00A3;
            5'd23: v = 32'h0000_0051;
            5'd24: v = 32'h0000_0029;
            5'd25: v = 32'h0000_0014;
            5'd26: v = 32'h0000_000A;
            5'd27: v = 32'h0000_0005;
            5'd28: v = 32'h0000_0003;
            5'd29: v = 32'h0000_0001;
            5'd30: v = 32'h0000_0001;
            5'd31: v = 32'h0000_0000;
        endcase
        return v;
    endfunction

endpackage

/* rtl/ddo_cordic.sv */
// ----------------------------------------------------------------------------
// ddo_cordic
// Iterative rotation-mode CORDIC: cosine and sine of a binary angle in Q2.30,
// one micro-rotation per cycle after a quadrant reduction.
// ----------------------------------------------------------------------------
module ddo_cordic
    import ddo_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_res o_res
);

    logic                    r_busy;
    logic                    r_fin;
    logic                    r_done;
    logic [STEP_W-1:0]       r_cnt;
    logic signed [33:0]      r_x;
    logic signed [33:0]      r_y;
    logic signed [33:0]      r_z;
    logic [1:0]              r_q;
    logic signed [32:0]      r_cos;
    logic signed [32:0]      r_sin;

    logic [31:0]             rot;
    logic [1:0]              q_start;
    logic [31:0]             z_start;
    logic signed [33:0]      dx;
    logic signed [33:0]      dy;
    logic signed [33:0]      atan_v;
    logic signed [33:0]      n_x;
    logic signed [33:0]      n_y;
    logic signed [33:0]      n_z;
    logic signed [33:0]      n_cos;
    logic signed [33:0]      n_sin;
    logic                    last;

    always_comb begin
        rot     = i_req.angle + 32'h2000_0000;
        q_start = rot[31:30];
        z_start = i_req.angle - {q_start, 30'd0};
        dx      = r_x >>> r_cnt;
        dy      = r_y >>> r_cnt;
        atan_v  = {2'b00, atan_q32(5'(r_cnt))};
        last    = (r_cnt == STEP_W'(CORDIC_STEPS - 1));
        if (!r_z[33]) begin
            n_x = r_x - dy;
            n_y = r_y + dx;
            n_z = r_z - atan_v;
        end else begin
            n_x = r_x + dy;
            n_y = r_y - dx;
            n_z = r_z + atan_v;
        end
        unique case (r_q)
            2'd0: begin
                n_cos = r_x;
                n_sin = r_y;
            end
            2'd1: begin
                n_cos = -r_y;
                n_sin = r_x;
            end
            2'd2: begin
                n_cos = -r_x;
                n_sin = -r_y;
            end
            2'd3: begin
                n_cos = r_y;
                n_sin = -r_x;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else if (i_req.start) begin
            r_busy <= 1'b1;
            r_fin  <= 1'b0;
            r_done <= 1'b0;
        end else if (r_busy && last) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b1;
        end else if (r_fin) begin
            r_fin  <= 1'b0;
            r_done <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_x   <= CORDIC_GAIN;
            r_y   <= '0;
            r_z   <= 34'($signed(z_start));
            r_q   <= q_start;
            r_cnt <= '0;
        end else if (r_busy) begin
            r_x   <= n_x;
            r_y   <= n_y;
            r_z   <= n_z;
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_fin) begin
            r_cos <= n_cos[32:0];
            r_sin <= n_sin[32:0];
        end
    end

    assign o_res.done    = r_done;
    assign o_res.cos_q30 = r_cos;
    assign o_res.sin_q30 = r_sin;

endmodule

/* rtl/differential_drive_odometry.sv */
// ----------------------------------------------------------------------------
// differential_drive_odometry
// Pose and velocity from cumulative wheel encoder counts.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carries left and right counts and a
// millisecond timestamp. An item that comes before the sample period has run
// out is accepted without a stall, gives no result and changes nothing.
// An item that is due starts an update; o_in_stall stays high until its
// result has been loaded into the output register.
// Output channel: o_out_valid / i_out_stall carries the pose and velocities.
// The update waits for the iterative CORDIC, which runs beside the shared
// 33x33 multiplier that works through ten products in sequence. The next
// item is taken the cycle after the result is loaded, even while the result
// still waits; if the receiver still stalls a finished result, the update
// holds in its last step until the output register is free.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index. The
// user must write it only while the block is idle; the block itself does
// not enforce this. Reset (i_rst_n low, synchronous) restores the register
// defaults and clears pose, heading and the last counts and timestamp.
// ----------------------------------------------------------------------------
module differential_drive_odometry
    import ddo_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic signed [31:0] i_left_count,
    input  logic signed [31:0] i_right_count,
    input  logic [31:0]        i_time_ms,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [31:0] o_x_pos,
    output logic signed [31:0] o_y_pos,
    output logic [31:0]        o_heading,
    output logic signed [31:0] o_linear_velocity,
    output logic signed [31:0] o_angular_velocity
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_PREP = 3'd1;
    localparam logic [2:0] S_ABS  = 3'd2;
    localparam logic [2:0] S_MUL  = 3'd3;
    localparam logic [2:0] S_OUT  = 3'd4;

    localparam logic [3:0] OP_P   = 4'd0;
    localparam logic [3:0] OP_M   = 4'd1;
    localparam logic [3:0] OP_LO  = 4'd2;
    localparam logic [3:0] OP_HI  = 4'd3;
    localparam logic [3:0] OP_VLO = 4'd4;
    localparam logic [3:0] OP_VHI = 4'd5;
    localparam logic [3:0] OP_WLO = 4'd6;
    localparam logic [3:0] OP_WHI = 4'd7;
    localparam logic [3:0] OP_XC  = 4'd8;
    localparam logic [3:0] OP_YS  = 4'd9;
    localparam logic [3:0] OP_END = 4'd10;

    function automatic logic [31:0] sat_signed(input logic neg, input logic [55:0] mag);
        logic big;
        big = |mag[55:31];
        if (neg) begin
            return big ? 32'h8000_0000 : (~mag[31:0] + 32'd1);
        end
        return big ? 32'h7FFF_FFFF : mag[31:0];
    endfunction

    function automatic logic [31:0] sat_add(input logic signed [31:0] a,
                                            input logic signed [35:0] b);
        logic signed [36:0] r;
        r = 37'(a) + 37'(b);
        if (~|r[36:31] || &r[36:31]) begin
            return r[31:0];
        end
        return r[36] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    endfunction

    // configuration and architectural state
    logic [31:0]        r_dist;
    logic [15:0]        r_period;
    logic [31:0]        r_rate;
    logic [31:0]        r_turns;
    logic [31:0]        r_last_left;
    logic [31:0]        r_last_right;
    logic [31:0]        r_last_ms;
    logic signed [31:0] r_pos_x;
    logic signed [31:0] r_pos_y;
    logic [31:0]        r_angle;

    // sequencer
    logic [2:0]         r_state;
    logic [3:0]         r_step;
    logic               r_mul_vld;
    logic [3:0]         r_mul_op;

    // datapath
    logic signed [31:0] r_dl;
    logic signed [31:0] r_dr;
    logic signed [32:0] r_sum;
    logic signed [32:0] r_dif;
    logic               r_sneg;
    logic               r_dneg;
    logic [32:0]        r_sm;
    logic [31:0]        r_dm;
    logic signed [65:0] r_prod;
    logic [63:0]        r_p;
    logic [39:0]        r_mean40;
    logic signed [31:0] r_mean;
    logic [31:0]        r_lo_hi;
    logic [55:0]        r_turn;
    logic [47:0]        r_vlo;
    logic [55:0]        r_vmag;
    logic [31:0]        r_wlo;
    logic [55:0]        r_wmag;

    // output register
    logic               r_out_valid;
    logic signed [31:0] r_x;
    logic signed [31:0] r_y;
    logic [31:0]        r_heading;
    logic signed [31:0] r_lin;
    logic signed [31:0] r_ang;

    logic               in_acc;
    logic [31:0]        elapsed;
    logic               early;
    logic               start;
    logic               mul_issue;
    logic               out_load;
    logic signed [32:0] mul_a;
    logic signed [32:0] mul_b;
    logic [32:0]        abs_sum;
    logic [32:0]        abs_dif;
    logic [64:0]        msum;
    logic [64:0]        tsum;
    logic [56:0]        vsum;
    logic [56:0]        wsum;
    logic [31:0]        n_pos_x;
    logic [31:0]        n_pos_y;
    logic [31:0]        n_angle;

    t_cordic_req        cordic_req;
    t_cordic_res        cordic_res;

    ddo_cordic u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (cordic_req),
        .o_res   (cordic_res)
    );

    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign elapsed    = i_time_ms - r_last_ms;
    assign early      = (elapsed < {16'd0, r_period});
    assign start      = in_acc && !early;

    assign cordic_req.start = start;
    assign cordic_req.angle = r_angle;

    assign mul_issue = (r_state == S_MUL) && (r_step != OP_END)
                       && !((r_step == OP_XC) && !cordic_res.done);
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || !i_out_stall);

    always_comb begin
        unique case (r_step)
            OP_P: begin
                mul_a = {1'b0, r_dm};
                mul_b = {1'b0, r_dist};
            end
            OP_M: begin
                mul_a = {1'b0, r_sm[31:0]};
                mul_b = {1'b0, r_dist};
            end
            OP_LO: begin
                mul_a = {1'b0, r_p[31:0]};
                mul_b = {1'b0, r_turns};
            end
            OP_HI: begin
                mul_a = {1'b0, r_p[63:32]};
                mul_b = {1'b0, r_turns};
            end
            OP_VLO: begin
                mul_a = {1'b0, r_mean40[31:0]};
                mul_b = {1'b0, r_rate};
            end
            OP_VHI: begin
                mul_a = {25'd0, r_mean40[39:32]};
                mul_b = {1'b0, r_rate};
            end
            OP_WLO: begin
                mul_a = {1'b0, r_turn[31:0]};
                mul_b = {1'b0, r_rate};
            end
            OP_WHI: begin
                mul_a = {9'd0, r_turn[55:32]};
                mul_b = {1'b0, r_rate};
            end
            OP_XC: begin
                mul_a = {r_mean[31], r_mean};
                mul_b = cordic_res.cos_q30;
            end
            OP_YS: begin
                mul_a = {r_mean[31], r_mean};
                mul_b = cordic_res.sin_q30;
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb begin
        abs_sum = r_sum[32] ? 33'(-r_sum) : r_sum;
        abs_dif = r_dif[32] ? 33'(-r_dif) : r_dif;
        msum    = {1'b0, r_prod[63:0]} + (r_sm[32] ? {1'b0, r_dist, 32'd0} : 65'd0);
        tsum    = {1'b0, r_prod[63:0]} + {33'd0, r_lo_hi};
        vsum    = {9'd0, r_vlo} + {1'b0, r_prod[39:0], 16'd0};
        wsum    = {1'b0, r_prod[55:0]} + {25'd0, r_wlo};
        n_pos_x = sat_add(r_pos_x, r_prod[65:30]);
        n_pos_y = sat_add(r_pos_y, r_prod[65:30]);
        n_angle = r_dneg ? (r_angle - r_turn[31:0]) : (r_angle + r_turn[31:0]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dist       <= DIST_RESET;
            r_period     <= PERIOD_RESET;
            r_rate       <= RATE_RESET;
            r_turns      <= TURNS_RESET;
            r_last_left  <= '0;
            r_last_right <= '0;
            r_last_ms    <= '0;
            r_pos_x      <= '0;
            r_pos_y      <= '0;
            r_angle      <= '0;
            r_state      <= S_IDLE;
            r_step       <= OP_P;
            r_mul_vld    <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_DIST:   r_dist   <= i_cfg_data;
                    REG_PERIOD: r_period <= i_cfg_data[15:0];
                    REG_RATE:   r_rate   <= i_cfg_data;
                    REG_TURNS:  r_turns  <= i_cfg_data;
                endcase
            end

            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_state      <= S_PREP;
                        r_last_left  <= i_left_count;
                        r_last_right <= i_right_count;
                        r_last_ms    <= i_time_ms;
                    end
                end
                S_PREP: begin
                    r_state <= S_ABS;
                end
                S_ABS: begin
                    r_state <= S_MUL;
                    r_step  <= OP_P;
                end
                S_MUL: begin
                    if (mul_issue) begin
                        r_step <= r_step + 4'd1;
                    end
                    if ((r_step == OP_END) && r_mul_vld) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                        r_angle <= n_angle;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase

            r_mul_vld <= mul_issue;
            if (r_mul_vld && (r_mul_op == OP_XC)) begin
                r_pos_x <= n_pos_x;
            end
            if (r_mul_vld && (r_mul_op == OP_YS)) begin
                r_pos_y <= n_pos_y;
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_dl <= i_left_count - r_last_left;
            r_dr <= i_right_count - r_last_right;
        end
        if (r_state == S_PREP) begin
            r_sum <= 33'(r_dl) + 33'(r_dr);
            r_dif <= 33'(r_dr) - 33'(r_dl);
        end
        if (r_state == S_ABS) begin
            r_sneg <= r_sum[32];
            r_dneg <= r_dif[32];
            r_sm   <= abs_sum;
            r_dm   <= abs_dif[31:0];
        end
        if (mul_issue) begin
            r_prod   <= mul_a * mul_b;
            r_mul_op <= r_step;
        end
        if (r_mul_vld) begin
            unique case (r_mul_op)
                OP_P:   r_p      <= r_prod[63:0];
                OP_M:   r_mean40 <= msum[64:25];
                OP_LO: begin
                    r_lo_hi <= r_prod[63:32];
                    r_mean  <= sat_signed(r_sneg, {16'd0, r_mean40});
                end
                OP_HI:  r_turn   <= tsum[63:8];
                OP_VLO: r_vlo    <= r_prod[63:16];
                OP_VHI: r_vmag   <= vsum[55:0];
                OP_WLO: r_wlo    <= r_prod[63:32];
                OP_WHI: r_wmag   <= wsum[55:0];
                default: begin
                end
            endcase
        end
        if (out_load) begin
            r_x       <= r_pos_x;
            r_y       <= r_pos_y;
            r_heading <= n_angle;
            r_lin     <= sat_signed(r_sneg, r_vmag);
            r_ang     <= sat_signed(r_dneg, r_wmag);
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_x_pos            = r_x;
    assign o_y_pos            = r_y;
    assign o_heading          = r_heading;
    assign o_linear_velocity  = r_lin;
    assign o_angular_velocity = r_ang;

    a_early_no_change: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && early |=> (r_state == S_IDLE) && $stable(r_last_ms)
                            && $stable(r_pos_x) && $stable(r_angle))
        else $error("early item changed state");

    a_mul_in_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_mul_vld |-> (r_state == S_MUL))
        else $error("product taken outside the multiply sequence");

    a_out_after_cordic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> cordic_res.done)
        else $error("result formed before rotation finished");

    a_heading_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_heading == r_angle))
        else $error("shown heading differs from stored heading");

    a_load_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_load |=> (r_state == S_IDLE) && r_out_valid)
        else $error("result load did not free the block");

endmodule

/* sim/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for differential_drive_odometry. Items go in through
// the valid/stall channel with random gaps while the result channel stalls at
// random. A behavioural model of the pose update (wrapped count deltas, mean
// travel, CORDIC rotation, saturating position and velocities) predicts each
// result, which is compared field by field. A short hand-written sequence
// comes first, then random runs under several register settings.
// ----------------------------------------------------------------------------
module testbench;
    import ddo_pkg::*;

    localparam int QUIET_LIMIT   = 2000;
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASES        = 8;
    localparam int RUN_ITEMS     = 179;
    localparam int OPENING_ROWS  = 19;
    localparam longint SAT_HIGH  = 64'sh0000_0000_7FFF_FFFF;
    localparam longint SAT_LOW   = 64'shFFFF_FFFF_8000_0000;
    localparam longint UNIT_GAIN = 652032874;

    localparam logic [31:0] ARCTAN_STEPS [0:31] = '{
        32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
        32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
        32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
        32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
        32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
        32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051,
        32'h0000_0029, 32'h0000_0014, 32'h0000_000A, 32'h0000_0005,
        32'h0000_0003, 32'h0000_0001, 32'h0000_0001, 32'h0000_0000
    };

    typedef struct packed {
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic [31:0]        heading;
        logic signed [31:0] lin;
        logic signed [31:0] ang;
    } pose_t;

    typedef enum logic [1:0] {FROM_MODEL, NO_RESULT, GIVEN} row_kind_t;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic [31:0] stamp;
        row_kind_t   kind;
        pose_t       given;
    } stim_row_t;

    localparam pose_t NO_POSE = '0;

    logic               i_clk = 1'b0;
    logic               i_rst_n;
    logic               i_cfg_we;
    logic [1:0]         i_cfg_index;
    logic [31:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_stall;
    logic signed [31:0] i_left_count;
    logic signed [31:0] i_right_count;
    logic [31:0]        i_time_ms;
    logic               o_out_valid;
    logic               i_out_stall = 1'b0;
    logic signed [31:0] o_x_pos;
    logic signed [31:0] o_y_pos;
    logic [31:0]        o_heading;
    logic signed [31:0] o_linear_velocity;
    logic signed [31:0] o_angular_velocity;

    differential_drive_odometry DUT (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_data         (i_cfg_data),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_left_count       (i_left_count),
        .i_right_count      (i_right_count),
        .i_time_ms          (i_time_ms),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_x_pos            (o_x_pos),
        .o_y_pos            (o_y_pos),
        .o_heading          (o_heading),
        .o_linear_velocity  (o_linear_velocity),
        .o_angular_velocity (o_angular_velocity)
    );

    always #10 i_clk = ~i_clk;

    // model copy of registers and state
    logic [31:0]        tick_len;
    logic [15:0]        min_gap_ms;
    logic [31:0]        rate_hz;
    logic [31:0]        turn_gain;
    logic [31:0]        prev_left;
    logic [31:0]        prev_right;
    logic [31:0]        prev_stamp;
    logic signed [31:0] pose_x;
    logic signed [31:0] pose_y;
    logic [31:0]        bearing;

    pose_t       expected_poses [$];
    row_kind_t   row_kind = FROM_MODEL;
    pose_t       row_given = '0;
    bit          send_idle_on = 1'b1;
    bit          recv_idle_on = 1'b1;
    int          stall_left = 0;
    int          quiet_cycles = 0;
    int unsigned errors = 0;
    int unsigned items_in = 0;
    int unsigned early_items = 0;
    int unsigned results_seen = 0;
    stim_row_t   opening_rows [0:OPENING_ROWS-1];

    function automatic logic signed [31:0] clamp_mag(input bit neg, input logic [63:0] mag);
        if (neg) begin
            if (mag >= 64'h8000_0000) return 32'sh8000_0000;
            return 32'(64'd0 - mag);
        end
        if (mag > 64'h7FFF_FFFF) return 32'sh7FFF_FFFF;
        return mag[31:0];
    endfunction

    function automatic logic signed [31:0] clamp_add(input logic signed [31:0] a,
                                                     input longint b);
        longint r;
        r = longint'(a) + b;
        if (r > SAT_HIGH) return 32'sh7FFF_FFFF;
        if (r < SAT_LOW) return 32'sh8000_0000;
        return 32'(r);
    endfunction

    // cos and sin of a binary angle in Q2.30, quadrant folded first
    function automatic void unit_vector(input logic [31:0] ang,
                                        output longint cos_v, output longint sin_v);
        logic [31:0]        shifted;
        logic [1:0]         q;
        logic signed [31:0] resid;
        longint             z, x, y, nx, dx, dy;
        shifted = ang + 32'h2000_0000;
        q       = shifted[31:30];
        resid   = ang - {q, 30'd0};
        z       = resid;
        x       = UNIT_GAIN;
        y       = 0;
        for (int i = 0; i < CORDIC_STEPS && i < 32; i++) begin
            dx = x >>> i;
            dy = y >>> i;
            if (z >= 0) begin
                nx = x - dy;
                y  = y + dx;
                z  = z - longint'({32'd0, ARCTAN_STEPS[i]});
            end else begin
                nx = x + dy;
                y  = y - dx;
                z  = z + longint'({32'd0, ARCTAN_STEPS[i]});
            end
            x = nx;
        end
        case (q)
            2'd0: begin cos_v = x;  sin_v = y;  end
            2'd1: begin cos_v = -y; sin_v = x;  end
            2'd2: begin cos_v = -x; sin_v = -y; end
            default: begin cos_v = y; sin_v = -x; end
        endcase
    endfunction

    // one encoder sample; returns 1 when it is due and yields a pose
    function automatic bit odometry_update(input logic [31:0] left, right, now,
                                           output pose_t res);
        logic [31:0]        elapsed, old;
        logic signed [31:0] dl, dr;
        longint             sum, dif, c, s, mean;
        bit                 sneg, dneg;
        logic [63:0]        sm, dm, p, turn, v, w;
        logic [127:0]       wide;
        res     = '0;
        elapsed = now - prev_stamp;
        if (elapsed < {16'd0, min_gap_ms}) return 1'b0;
        prev_stamp = now;
        dl         = left - prev_left;
        dr         = right - prev_right;
        prev_left  = left;
        prev_right = right;
        sum  = longint'(dl) + longint'(dr);
        dif  = longint'(dr) - longint'(dl);
        sneg = sum < 0;
        dneg = dif < 0;
        sm   = sneg ? -sum : sum;
        dm   = dneg ? -dif : dif;
        sm   = (sm * tick_len) >> 25;
        p    = dm * tick_len;
        wide = {64'd0, p} * {96'd0, turn_gain};
        turn = wide[103:40];
        old  = bearing;
        unit_vector(old, c, s);
        mean    = longint'(clamp_mag(sneg, sm));
        pose_x  = clamp_add(pose_x, (mean * c) >>> 30);
        pose_y  = clamp_add(pose_y, (mean * s) >>> 30);
        bearing = dneg ? old - turn[31:0] : old + turn[31:0];
        wide = {64'd0, sm} * {96'd0, rate_hz};
        v    = wide[79:16];
        wide = {64'd0, turn} * {96'd0, rate_hz};
        w    = wide[95:32];
        res.x       = pose_x;
        res.y       = pose_y;
        res.heading = bearing;
        res.lin     = clamp_mag(sneg, v);
        res.ang     = clamp_mag(dneg, w);
        return 1'b1;
    endfunction

    function automatic void check_field(input string field, input logic [31:0] want, got);
        if (want !== got) begin
            if (errors < 10)
                $display("mismatch on %s: expected %h, got %h", field, want, got);
            errors++;
        end
    endfunction

    // result stall, mostly spent while a result waits
    always @(negedge i_clk) begin
        i_out_stall = (stall_left > 0);
        if (stall_left > 0 && (o_out_valid || $urandom_range(0, 3) == 0))
            stall_left = stall_left - 1;
    end

    always @(posedge i_clk) begin : monitor
        pose_t seen, want;
        bit    due, active;
        if (!i_rst_n) begin
            tick_len     = 32'd25108448;
            min_gap_ms   = 16'd50;
            rate_hz      = 32'd1310720;
            turn_gain    = 32'd1667232380;
            prev_left    = '0;
            prev_right   = '0;
            prev_stamp   = '0;
            pose_x       = '0;
            pose_y       = '0;
            bearing      = '0;
            quiet_cycles = 0;
        end else begin
            active = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                active = 1'b1;
                results_seen++;
                seen = '{o_x_pos, o_y_pos, o_heading, o_linear_velocity,
                         o_angular_velocity};
                if (expected_poses.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result: x %h y %h heading %h lin %h ang %h",
                                 seen.x, seen.y, seen.heading, seen.lin, seen.ang);
                    errors++;
                end else begin
                    want = expected_poses.pop_front();
                    check_field("x_pos", want.x, seen.x);
                    check_field("y_pos", want.y, seen.y);
                    check_field("heading", want.heading, seen.heading);
                    check_field("linear_velocity", want.lin, seen.lin);
                    check_field("angular_velocity", want.ang, seen.ang);
                end
                stall_left = recv_idle_on ? int'($urandom_range(0, 15)) : 0;
            end
            if (i_in_valid && !o_in_stall) begin
                active = 1'b1;
                items_in++;
                due = odometry_update(i_left_count, i_right_count, i_time_ms, want);
                if (row_kind == NO_RESULT) due = 1'b0;
                if (row_kind == GIVEN) begin
                    due  = 1'b1;
                    want = row_given;
                end
                if (due) expected_poses.push_back(want);
                else early_items++;
            end
            if (i_cfg_we) begin
                active = 1'b1;
                case (i_cfg_index)
                    REG_DIST:   tick_len   = i_cfg_data;
                    REG_PERIOD: min_gap_ms = i_cfg_data[15:0];
                    REG_RATE:   rate_hz    = i_cfg_data;
                    REG_TURNS:  turn_gain  = i_cfg_data;
                    default: ;
                endcase
            end
            if (active) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles = quiet_cycles + 1;
                if (quiet_cycles >= QUIET_LIMIT) begin
                    $display("timeout: no handshake for %0d cycles", QUIET_LIMIT);
                    $display("tb: failure");
                    $finish;
                end
            end
        end
    end

    task automatic push_sample(input logic [31:0] left, right, stamp,
                               input row_kind_t kind, input pose_t given);
        int gap;
        gap = send_idle_on ? int'($urandom_range(0, 15)) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    = 1'b1;
        i_left_count  = left;
        i_right_count = right;
        i_time_ms     = stamp;
        row_kind      = kind;
        row_given     = given;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drain every result and let any early item clear before a register write
    task automatic settle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
        @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
    endtask

    initial begin
        logic [31:0] wheel_l, wheel_r, stamp, tick_word, period_word, rate, turns, step;
        logic [15:0] period;
        int unsigned span, pick;

        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = REG_DIST;
        i_cfg_data    = '0;
        i_in_valid    = 1'b0;
        i_left_count  = '0;
        i_right_count = '0;
        i_time_ms     = '0;

        opening_rows = '{
            '{32'd0, 32'd0, 32'd0, NO_RESULT, NO_POSE},
            '{32'd5, 32'd5, 32'd49, NO_RESULT, NO_POSE},
            '{32'd0, 32'd0, 32'd50, GIVEN,
              '{x: 32'sd0, y: 32'sd0, heading: 32'd0, lin: 32'sd0, ang: 32'sd0}},
            '{32'd1000, 32'd1000, 32'd100, FROM_MODEL, NO_POSE},
            '{-32'sd1000, 32'd3000, 32'd150, FROM_MODEL, NO_POSE},
            '{32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd200, FROM_MODEL, NO_POSE},
            '{32'h8000_0000, 32'h7FFF_FFFF, 32'd250, FROM_MODEL, NO_POSE},
            '{32'h8000_0000, 32'h8000_0000, 32'd300, FROM_MODEL, NO_POSE},
            '{32'd0, 32'd0, 32'd349, NO_RESULT, NO_POSE},
            '{32'd0, 32'd0, 32'hFFFF_FFFF, FROM_MODEL, NO_POSE},
            '{32'd10, 32'd10, 32'd49, FROM_MODEL, NO_POSE},
            '{32'd10, 32'd10, 32'd98, NO_RESULT, NO_POSE},
            '{32'd10, 32'd10, 32'd99, FROM_MODEL, NO_POSE},
            '{-32'sd500, 32'd500, 32'd150, FROM_MODEL, NO_POSE},
            '{32'd5000, -32'sd5000, 32'd200, FROM_MODEL, NO_POSE},
            '{32'h0000_FFFF, 32'hFFFF_0000, 32'd300, FROM_MODEL, NO_POSE},
            '{32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, FROM_MODEL, NO_POSE},
            '{32'hAAAA_AAAA, 32'h5555_5555, 32'hC000_0000, FROM_MODEL, NO_POSE},
            '{32'd0, 32'd0, 32'hC000_0031, NO_RESULT, NO_POSE}
        };

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // hand-written sequence at reset register values
        for (int n = 0; n < OPENING_ROWS; n++)
            push_sample(opening_rows[n].left, opening_rows[n].right, opening_rows[n].stamp,
                        opening_rows[n].kind, opening_rows[n].given);
        wheel_l = opening_rows[OPENING_ROWS-1].left;
        wheel_r = opening_rows[OPENING_ROWS-1].right;
        stamp   = opening_rows[OPENING_ROWS-1].stamp;

        for (int ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0: begin
                    tick_word = 32'd25108448; period_word = 32'd50;
                    rate = 32'd1310720;  turns = 32'd1667232380;
                end
                1: begin
                    // upper bits of the period word drop, leaving a zero period
                    tick_word = 32'hFFFF_FFFF; period_word = 32'h0001_0000;
                    rate = 32'hFFFF_FFFF; turns = 32'hFFFF_FFFF;
                end
                2: begin
                    tick_word = 32'd0; period_word = 32'hFFFF_0001;
                    rate = 32'd0; turns = 32'd0;
                end
                3: begin
                    tick_word = 32'd1; period_word = 32'd65535;
                    rate = 32'd1; turns = 32'd1;
                end
                4: begin
                    tick_word = 32'd25108448; period_word = 32'd20;
                    rate = 32'd3276800;  turns = 32'd1667232380;
                end
                default: begin
                    tick_word   = $urandom >> $urandom_range(0, 24);
                    period_word = ($urandom & 32'hFFFF_0000) | $urandom_range(0, 200);
                    rate        = $urandom >> $urandom_range(0, 24);
                    turns       = $urandom >> $urandom_range(0, 8);
                end
            endcase
            settle();
            write_reg(REG_DIST, tick_word);
            write_reg(REG_PERIOD, period_word);
            write_reg(REG_RATE, rate);
            write_reg(REG_TURNS, turns);
            @(negedge i_clk);
            i_cfg_we = 1'b0;
            period   = period_word[15:0];

            for (int n = 0; n < RUN_ITEMS; n++) begin
                if (n % 40 == 0) begin
                    pick         = $urandom_range(0, 3);
                    send_idle_on = pick[0];
                    recv_idle_on = pick[1];
                end
                pick = $urandom_range(0, 99);
                if (pick < 90) begin
                    span = $urandom_range(0, 9);
                    span = (span < 6) ? 2000 : (span < 9) ? 200000 : 32'h4000_0000;
                    step    = $urandom_range(0, 2 * span) - span;
                    wheel_l = wheel_l + step;
                    step    = $urandom_range(0, 2 * span) - span;
                    wheel_r = wheel_r + step;
                    if (pick < 78)
                        stamp = stamp + period + $urandom_range(0, period / 4 + 2);
                    else if (period != 0)
                        stamp = stamp + $urandom_range(0, period - 1);
                end else begin
                    // noise: arbitrary counts, sometimes an arbitrary timestamp
                    wheel_l = $urandom;
                    wheel_r = $urandom;
                    if (pick[0]) stamp = $urandom;
                end
                push_sample(wheel_l, wheel_r, stamp, FROM_MODEL, NO_POSE);
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (expected_poses.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        errors = errors + expected_poses.size();

        $display("summary: %0d items sent, %0d early, %0d results checked, %0d mismatches",
                 items_in, early_items, results_seen, errors);
        $display("summary: reset values plus %0d register settings incl. zero and full scale",
                 PHASES);
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
